@@ rtl/core/aes128_pkg.sv @@
// AES-128 package: S-box, round constants, round and key-step functions.
// Used by every file of the block encrypt unit; depends on nothing.
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int CfgIdxWidth = 8;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_LOW  = 8'd1;

    typedef logic [127:0] block_t;
    typedef logic [3:0]   round_idx_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [0:255];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[a];
    endfunction

    function automatic logic [7:0] rcon(input round_idx_t r);
        logic [7:0] v;
        unique case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input block_t s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic block_t next_round_key(input block_t k, input round_idx_t r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        t[31:24] = t[31:24] ^ rcon(r);
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic block_t enc_round(input block_t s, input block_t k,
                                         input logic last);
        block_t t;
        block_t m;
        logic [7:0] a, b, d, e, x;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
            end
        end
        m = t;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a = get_byte(t, 4*c);
                b = get_byte(t, 4*c+1);
                d = get_byte(t, 4*c+2);
                e = get_byte(t, 4*c+3);
                x = a ^ b ^ d ^ e;
                m[127-8*(4*c) -: 8]   = a ^ x ^ xtime(a ^ b);
                m[127-8*(4*c+1) -: 8] = b ^ x ^ xtime(b ^ d);
                m[127-8*(4*c+2) -: 8] = d ^ x ^ xtime(d ^ e);
                m[127-8*(4*c+3) -: 8] = e ^ x ^ xtime(e ^ a);
            end
        end
        return m ^ k;
    endfunction

endpackage

@@ rtl/core/aes128_if.sv @@
// Valid/ready channel interfaces for blocks and configuration writes.
// Depends on aes128_pkg.
interface aes128_block_if;
    logic valid;
    logic ready;
    logic [63:0] high;
    logic [63:0] low;
    modport source (output valid, output high, output low, input ready);
    modport sink (input valid, input high, input low, output ready);
endinterface

interface aes128_cfg_if;
    logic valid;
    logic ready;
    logic [aes128_pkg::CfgIdxWidth-1:0] index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/aes128_block_encrypt_unit.sv @@
// AES-128 encrypt: row of ten round cells after an AddRoundKey stage.
// Eleven register stages from input beat accept to ciphertext valid; throughput one
// block per cycle unless stalled or held off by the key schedule; the row stalls as one.
// Key schedule: after a key write, the key cells load in turn (one round key per cycle)
// with the input held off; write config only while the row is empty.
// Reset clears valid bits, the key registers and the schedule counter; round keys are
// undefined until the first key write.
module aes128_block_encrypt_unit (
    input  logic clk,
    input  logic rst_n,
    aes128_block_if.sink   plaintext,
    aes128_block_if.source ciphertext,
    aes128_cfg_if.sink     cfg
);
    localparam int N = aes128_pkg::NumRounds;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_next;
    logic [63:0] key_low_next;
    logic        key_wr;
    logic [3:0]  sched_cnt_reg;
    logic [3:0]  sched_cnt_next;
    logic        sched_busy;

    aes128_pkg::block_t rk [0:N];
    aes128_pkg::block_t st [0:N];
    logic               vl [0:N];
    logic               advance;

    logic               v0_reg;
    aes128_pkg::block_t s0_reg;

    assign cfg.ready = 1'b1;
    assign key_wr = cfg.valid &&
        (cfg.index == aes128_pkg::REG_KEY_HIGH || cfg.index == aes128_pkg::REG_KEY_LOW);

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg.valid && cfg.index == aes128_pkg::REG_KEY_HIGH)
        begin
            key_high_next = cfg.data;
        end
        if (cfg.valid && cfg.index == aes128_pkg::REG_KEY_LOW)
        begin
            key_low_next = cfg.data;
        end
    end

    assign sched_busy = (sched_cnt_reg != 4'd0);

    always_comb
    begin
        sched_cnt_next = sched_cnt_reg;
        if (key_wr)
        begin
            sched_cnt_next = 4'd1;
        end
        else if (sched_busy)
        begin
            sched_cnt_next = (sched_cnt_reg == 4'(N)) ? 4'd0 : sched_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            sched_cnt_reg <= '0;
        end
        else
        begin
            key_high_reg  <= key_high_next;
            key_low_reg   <= key_low_next;
            sched_cnt_reg <= sched_cnt_next;
        end
    end

    // advance the key row one cell per cycle; each cell loads on its own step
    assign rk[0] = {key_high_reg, key_low_reg};

    genvar g;
    generate
        for (g = 1; g <= N; g++)
        begin : g_key
            aes128_key_cell u_key (
                .clk       (clk),
                .load      (sched_cnt_reg == 4'(g)),
                .prev_key  (rk[g-1]),
                .round     (4'(g)),
                .round_key (rk[g])
            );
        end
    endgenerate

    assign advance = !vl[N] || ciphertext.ready;
    assign plaintext.ready = advance && !sched_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= plaintext.valid && !sched_busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= {plaintext.high, plaintext.low} ^ rk[0];
        end
    end

    assign vl[0] = v0_reg;
    assign st[0] = s0_reg;

    generate
        for (g = 1; g <= N; g++)
        begin : g_round
            aes128_round_cell u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .last      (g == N),
                .in_valid  (vl[g-1]),
                .in_state  (st[g-1]),
                .round_key (rk[g]),
                .out_valid (vl[g]),
                .out_state (st[g])
            );
        end
    endgenerate

    assign ciphertext.valid = vl[N];
    assign ciphertext.high  = st[N][127:64];
    assign ciphertext.low   = st[N][63:0];
endmodule

@@ rtl/core/aes128_key_cell.sv @@
// One key schedule cell: holds a round key, derives the next one.
// Depends on aes128_pkg.
module aes128_key_cell (
    input  logic                     clk,
    input  logic                     load,
    input  aes128_pkg::block_t       prev_key,
    input  aes128_pkg::round_idx_t   round,
    output aes128_pkg::block_t       round_key
);
    aes128_pkg::block_t key_reg;
    aes128_pkg::block_t key_next;

    assign key_next = aes128_pkg::next_round_key(prev_key, round);
    assign round_key = key_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= key_next;
        end
    end
endmodule

@@ rtl/core/aes128_round_cell.sv @@
// One cipher round cell: registered state and valid, stalls with the row.
// Depends on aes128_pkg.
module aes128_round_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 last,
    input  logic                 in_valid,
    input  aes128_pkg::block_t   in_state,
    input  aes128_pkg::block_t   round_key,
    output logic                 out_valid,
    output aes128_pkg::block_t   out_state
);
    logic               valid_reg;
    aes128_pkg::block_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= aes128_pkg::enc_round(in_state, round_key, last);
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
endmodule
